// ----- design/mit_pkg.sv -----
`timescale 1ns / 1ps
// mit_pkg: shared types, constants and helpers of the mesh interaction tally
// no dependencies

package mit_pkg;

	localparam int COORD_W    = 32;
	localparam int COUNT_W    = 32;
	localparam int SLOTS      = 5;
	localparam int SLOT_W     = 3;
	localparam int TYPE_W     = 3;
	localparam int READ_CELL_W = 12;
	localparam int REG_IDX_W  = 3;
	localparam int AXIS_W     = 8;
	localparam int MUL_W      = COORD_W + AXIS_W;
	localparam int CELL_IDX_W = 3 * AXIS_W;

	localparam logic [COORD_W-1:0] BOX_MAX_RESET = 32'h0010_0000;

	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	localparam logic [TYPE_W-1:0] TYPE_FIRST = 3'd1;
	localparam logic [TYPE_W-1:0] TYPE_LAST  = 3'd4;

	localparam logic [SLOT_W-1:0] SLOT_TOTAL = 3'd0;

	localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

	typedef logic [SLOTS-1:0][COUNT_W-1:0] row_t;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_BUMP  = 2'd1,
		OP_CLEAR = 2'd2
	} store_op_t;

	typedef struct packed {
		logic                  valid;
		store_op_t             op;
		logic [CELL_IDX_W-1:0] addr;
		logic [SLOT_W-1:0]     slot;
	} store_cmd_t;

	typedef struct packed {
		logic               done;
		logic [COUNT_W-1:0] count;
	} store_res_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		logic [COUNT_W-1:0] r;
		r = (v == '1) ? v : v + COUNT_W'(1);
		return r;
	endfunction

endpackage

// ----- design/mit_axis_unit.sv -----
`timescale 1ns / 1ps
// mit_axis_unit: box test and cell number on one axis, floor(off * RES / span)
// offset multiply, then a bit-serial restoring divider; uses mit_pkg

module mit_axis_unit #(
	parameter int RES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [mit_pkg::COORD_W-1:0] p,
	input  logic signed [mit_pkg::COORD_W-1:0] lo,
	input  logic signed [mit_pkg::COORD_W-1:0] hi,
	output logic                          done,
	output logic                          in_box,
	output logic [mit_pkg::AXIS_W-1:0]    cell_idx
);
	import mit_pkg::*;

	localparam int CNT_W = $clog2(AXIS_W + 1);
	localparam logic [MUL_W-1:0] RES_M = MUL_W'(RES);

	logic                 v1_q;
	logic                 run_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 in_q;
	logic [COORD_W-1:0]   off_q;
	logic [COORD_W-1:0]   span_q;
	logic [COORD_W-1:0]   rem_q;
	logic [AXIS_W-1:0]    low_q;
	logic [AXIS_W-1:0]    quo_q;
	logic [MUL_W-1:0]     prod;
	logic [COORD_W:0]     trial;
	logic [COORD_W:0]     diff;
	logic                 ge;

	assign prod  = MUL_W'(off_q) * RES_M;
	assign trial = {rem_q, low_q[AXIS_W-1]};
	assign ge    = trial >= {1'b0, span_q};
	assign diff  = trial - {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			v1_q   <= start;
			done_q <= 1'b0;
			if (v1_q) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(AXIS_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			in_q   <= (p >= lo) && (p < hi);
			off_q  <= p - lo;
			span_q <= hi - lo;
		end
		if (v1_q) begin
			rem_q <= prod[MUL_W-1:AXIS_W];
			low_q <= prod[AXIS_W-1:0];
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
			low_q <= {low_q[AXIS_W-2:0], 1'b0};
			quo_q <= {quo_q[AXIS_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign in_box   = in_q;
	assign cell_idx = quo_q;

endmodule

// ----- design/mit_tally_store.sv -----
`timescale 1ns / 1ps
// mit_tally_store: one row of five saturating counts per cell, read-modify-write
// registered read, bump written back in the cycle after the read; uses mit_pkg

module mit_tally_store #(
	parameter int CELLS = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mit_pkg::store_cmd_t cmd,
	output mit_pkg::store_res_t res
);
	import mit_pkg::*;

	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

	row_t               mem [CELLS];
	row_t               row_s1;
	row_t               bumped;
	logic               v_s1;
	store_op_t          op_s1;
	logic [AW-1:0]      addr_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic               done_q;
	logic [COUNT_W-1:0] count_q;
	logic               rd_en;
	logic               we;
	logic [AW-1:0]      waddr;
	row_t               wdata;

	assign rd_en = cmd.valid && (cmd.op != OP_CLEAR);

	always_comb begin
		bumped               = row_s1;
		bumped[SLOT_TOTAL]   = sat_inc(row_s1[SLOT_TOTAL]);
		bumped[slot_s1]      = sat_inc(row_s1[slot_s1]);
	end

	always_comb begin
		we    = 1'b0;
		waddr = AW'(cmd.addr);
		wdata = '0;
		if (cmd.valid && cmd.op == OP_CLEAR) begin
			we = 1'b1;
		end else if (v_s1 && op_s1 == OP_BUMP) begin
			we    = 1'b1;
			waddr = addr_s1;
			wdata = bumped;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			row_s1  <= mem[AW'(cmd.addr)];
			op_s1   <= cmd.op;
			addr_s1 <= AW'(cmd.addr);
			slot_s1 <= cmd.slot;
		end
		if (v_s1) begin
			count_q <= (op_s1 == OP_BUMP) ? bumped[slot_s1] : row_s1[slot_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= rd_en;
			done_q <= v_s1;
		end
	end

	assign res.done  = done_q;
	assign res.count = count_q;

endmodule

// ----- design/mesh_interaction_tally.sv -----
`timescale 1ns / 1ps
// mesh_interaction_tally: uniform 3-d mesh that counts interaction points per cell and type
// uses mit_pkg, mit_axis_unit, mit_tally_store
//
// channel  handshake             payload
// in       in_valid / in_ready   action, point_x/y/z, interaction_type, read_cell, read_slot
// out      out_valid / out_ready counted, cell_number, slot_count, saturated
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data (box bounds, always ready)
//
// one transaction at a time: a scored record runs an 8-step serial divider per axis, then a
// read-modify-write of the cell row; a record outside the box skips the store, a read
// only reads the row, an ignored record or out-of-range read goes straight to S_OUT
// after reset the store is cleared one cell row per cycle, all RES_X*RES_Y*RES_Z rows,
// with in_ready low; cfg writes are taken throughout
// a result waiting on out_ready lets the next in transaction run up to S_OUT, where it waits

module mesh_interaction_tally #(
	parameter int RES_X = 16,
	parameter int RES_Y = 16,
	parameter int RES_Z = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 action,
	input  logic signed [mit_pkg::COORD_W-1:0]   point_x,
	input  logic signed [mit_pkg::COORD_W-1:0]   point_y,
	input  logic signed [mit_pkg::COORD_W-1:0]   point_z,
	input  logic [mit_pkg::TYPE_W-1:0]           interaction_type,
	input  logic [mit_pkg::READ_CELL_W-1:0]      read_cell,
	input  logic [mit_pkg::SLOT_W-1:0]           read_slot,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 counted,
	output logic [mit_pkg::READ_CELL_W-1:0]      cell_number,
	output logic [mit_pkg::COUNT_W-1:0]          slot_count,
	output logic                                 saturated,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mit_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [mit_pkg::COORD_W-1:0]          cfg_data
);
	import mit_pkg::*;

	localparam int CELLS = RES_X * RES_Y * RES_Z;
	localparam logic [CELL_IDX_W-1:0] LAST_CELL = CELL_IDX_W'(CELLS - 1);
	localparam logic [CELL_IDX_W-1:0] MUL_Y = CELL_IDX_W'(RES_X);
	localparam logic [CELL_IDX_W-1:0] MUL_Z = CELL_IDX_W'(RES_X * RES_Y);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_DIV   = 5'b00100,
		S_MEM   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [CELL_IDX_W-1:0]    clr_q;
	logic signed [COORD_W-1:0] box_min_q [3];
	logic signed [COORD_W-1:0] box_max_q [3];
	logic [TYPE_W-1:0]        type_q;
	logic                     res_counted_q;
	logic [READ_CELL_W-1:0]   res_cell_q;
	logic [COUNT_W-1:0]       res_count_q;
	logic                     out_valid_q;
	logic                     counted_q;
	logic [READ_CELL_W-1:0]   cell_number_q;
	logic [COUNT_W-1:0]       slot_count_q;
	logic                     saturated_q;

	logic                     accept;
	logic                     type_ok;
	logic                     rd_ok;
	logic                     ax_start;
	logic [2:0]               ax_done;
	logic [2:0]               ax_in;
	logic [AXIS_W-1:0]        ax_cell [3];
	logic [CELL_IDX_W-1:0]    cell_full;
	logic                     out_load;
	store_cmd_t               cmd;
	store_res_t               st_res;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign type_ok   = interaction_type inside {[TYPE_FIRST:TYPE_LAST]};
	assign rd_ok     = (32'(read_cell) < 32'(CELLS)) && (32'(read_slot) < 32'(SLOTS));
	assign ax_start  = accept && (action == ACT_RECORD) && type_ok;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	assign cell_full = CELL_IDX_W'(ax_cell[0])
		+ CELL_IDX_W'(ax_cell[1]) * MUL_Y
		+ CELL_IDX_W'(ax_cell[2]) * MUL_Z;

	mit_axis_unit #(.RES(RES_X)) u_axis_x (
		.clk(clk), .arst_n(arst_n), .start(ax_start), .p(point_x),
		.lo(box_min_q[0]), .hi(box_max_q[0]),
		.done(ax_done[0]), .in_box(ax_in[0]), .cell_idx(ax_cell[0])
	);

	mit_axis_unit #(.RES(RES_Y)) u_axis_y (
		.clk(clk), .arst_n(arst_n), .start(ax_start), .p(point_y),
		.lo(box_min_q[1]), .hi(box_max_q[1]),
		.done(ax_done[1]), .in_box(ax_in[1]), .cell_idx(ax_cell[1])
	);

	mit_axis_unit #(.RES(RES_Z)) u_axis_z (
		.clk(clk), .arst_n(arst_n), .start(ax_start), .p(point_z),
		.lo(box_min_q[2]), .hi(box_max_q[2]),
		.done(ax_done[2]), .in_box(ax_in[2]), .cell_idx(ax_cell[2])
	);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.valid = 1'b1;
				cmd.op    = OP_CLEAR;
				cmd.addr  = clr_q;
			end
			S_IDLE: begin
				if (accept && action == ACT_READ && rd_ok) begin
					cmd.valid = 1'b1;
					cmd.op    = OP_READ;
					cmd.addr  = CELL_IDX_W'(read_cell);
					cmd.slot  = read_slot;
				end
			end
			S_DIV: begin
				if (ax_done[0] && ax_done[1] && ax_done[2] && (&ax_in)) begin
					cmd.valid = 1'b1;
					cmd.op    = OP_BUMP;
					cmd.addr  = cell_full;
					cmd.slot  = SLOT_W'(type_q);
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	mit_tally_store #(.CELLS(CELLS)) u_store (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(st_res)
	);

	// box bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				box_min_q[i] <= '0;
				box_max_q[i] <= BOX_MAX_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BOX_MIN_X: box_min_q[0] <= cfg_data;
				REG_BOX_MIN_Y: box_min_q[1] <= cfg_data;
				REG_BOX_MIN_Z: box_min_q[2] <= cfg_data;
				REG_BOX_MAX_X: box_max_q[0] <= cfg_data;
				REG_BOX_MAX_Y: box_max_q[1] <= cfg_data;
				REG_BOX_MAX_Z: box_max_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CELL_IDX_W'(1);
					if (clr_q == LAST_CELL) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (action == ACT_RECORD) begin
							state_q <= type_ok ? S_DIV : S_OUT;
						end else begin
							state_q <= rd_ok ? S_MEM : S_OUT;
						end
					end
				end
				S_DIV: begin
					if (ax_done[0]) begin
						state_q <= (&ax_in) ? S_MEM : S_OUT;
					end
				end
				S_MEM: begin
					if (st_res.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					type_q        <= interaction_type;
					res_counted_q <= 1'b0;
					res_count_q   <= '0;
					res_cell_q    <= (action == ACT_READ) ? read_cell : '0;
				end
			end
			S_DIV: begin
				if (ax_done[0] && (&ax_in)) begin
					res_counted_q <= 1'b1;
					res_cell_q    <= cell_full[READ_CELL_W-1:0];
				end
			end
			S_MEM: begin
				if (st_res.done) begin
					res_count_q <= st_res.count;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			counted_q     <= res_counted_q;
			cell_number_q <= res_cell_q;
			slot_count_q  <= res_count_q;
			saturated_q   <= (res_count_q == '1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign counted     = counted_q;
	assign cell_number = cell_number_q;
	assign slot_count  = slot_count_q;
	assign saturated   = saturated_q;

endmodule
